// File: rtl/wsr_pkg.sv
// Package with the shared types, widths and codes of the writeback slot reservation block.
package wsr_pkg;

    localparam int WSR_NUM_BUSES     = 4;
    localparam int WSR_LATENCY_SLOTS = 64;

    localparam int CNT_W      = 3;
    localparam int LAT_W      = 6;
    localparam int BANK_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic REG_PORTS_PER_SLOT = 1'b0;

    localparam logic [CNT_W-1:0] PORTS_RESET = 3'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_WRITE2
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic tick_en;
        logic eval_en;
        logic write2_en;
        logic clear_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_write2;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/wsr_req_if.sv
// Request channel interface carrying ticks and reservation requests.
interface wsr_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [wsr_pkg::LAT_W-1:0] latency;
    logic                      first_valid;
    logic [wsr_pkg::BANK_W-1:0] first_bank;
    logic                      second_valid;
    logic [wsr_pkg::BANK_W-1:0] second_bank;

    modport source (
        output valid, cmd, latency, first_valid, first_bank, second_valid, second_bank,
        input  ready
    );

    modport sink (
        input  valid, cmd, latency, first_valid, first_bank, second_valid, second_bank,
        output ready
    );
endinterface

// File: rtl/wsr_resp_if.sv
// Response channel interface carrying the grant decision of a request.
interface wsr_resp_if;
    logic valid;
    logic ready;
    logic granted;

    modport source (
        output valid, granted,
        input  ready
    );

    modport sink (
        input  valid, granted,
        output ready
    );
endinterface

// File: rtl/wsr_ram.sv
// Generic RAM with one write port and two registered read ports.
module wsr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: rtl/wsr_ctrl.sv
// Controller state machine sequencing clear, tick, evaluation and second write.
module wsr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_cmd,
    input  wsr_pkg::dp_status_t    status,
    output wsr_pkg::ctrl_cmd_t     cmd
);

    wsr_pkg::state_t state_reg;
    wsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsr_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = wsr_pkg::ST_IDLE;
                end
            end
            wsr_pkg::ST_IDLE:
            begin
                if (in_valid && in_cmd == wsr_pkg::CMD_REQUEST)
                begin
                    state_next = wsr_pkg::ST_EVAL;
                end
            end
            wsr_pkg::ST_EVAL:
            begin
                if (!status.out_busy)
                begin
                    state_next = status.need_write2 ? wsr_pkg::ST_WRITE2 : wsr_pkg::ST_IDLE;
                end
            end
            wsr_pkg::ST_WRITE2:
            begin
                state_next = wsr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            wsr_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            wsr_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.capture  = in_valid && in_cmd == wsr_pkg::CMD_REQUEST;
                cmd.tick_en  = in_valid && in_cmd == wsr_pkg::CMD_TICK;
            end
            wsr_pkg::ST_EVAL:
            begin
                cmd.eval_en = !status.out_busy;
            end
            wsr_pkg::ST_WRITE2:
            begin
                cmd.write2_en = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/wsr_dp.sv
// Datapath with slot pointers, request decision, row updates and result register.
module wsr_dp #(
    parameter int NUM_BUSES     = wsr_pkg::WSR_NUM_BUSES,
    parameter int LATENCY_SLOTS = wsr_pkg::WSR_LATENCY_SLOTS,
    parameter int ROW_W         = $clog2(LATENCY_SLOTS),
    parameter int DATA_W        = NUM_BUSES * wsr_pkg::CNT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsr_pkg::ctrl_cmd_t           cmd,
    output wsr_pkg::dp_status_t          status,
    input  logic [wsr_pkg::LAT_W-1:0]    latency,
    input  logic                         first_valid,
    input  logic [wsr_pkg::BANK_W-1:0]   first_bank,
    input  logic                         second_valid,
    input  logic [wsr_pkg::BANK_W-1:0]   second_bank,
    input  logic [wsr_pkg::CNT_W-1:0]    ports_per_slot,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         granted,
    output logic                         ram_we,
    output logic [ROW_W-1:0]             ram_waddr,
    output logic [DATA_W-1:0]            ram_wdata,
    output logic                         ram_re,
    output logic [ROW_W-1:0]             ram_raddr_a,
    output logic [ROW_W-1:0]             ram_raddr_b,
    input  logic [DATA_W-1:0]            ram_rdata_a,
    input  logic [DATA_W-1:0]            ram_rdata_b
);

    localparam int SUM_W = ((ROW_W > wsr_pkg::LAT_W) ? ROW_W : wsr_pkg::LAT_W) + 1;
    localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(LATENCY_SLOTS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LATENCY_SLOTS - 1);

    typedef logic [NUM_BUSES-1:0][wsr_pkg::CNT_W-1:0] row_t;

    logic [ROW_W-1:0]          base_reg;
    logic [ROW_W-1:0]          base_next;
    logic [ROW_W-1:0]          clr_cnt_reg;
    logic [ROW_W-1:0]          clr_cnt_next;
    logic [ROW_W-1:0]          row_lat_reg;
    logic [ROW_W-1:0]          row_nxt_reg;
    logic                      lat_ok_reg;
    logic                      nxt_ok_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic [wsr_pkg::BANK_W-1:0] b1_reg;
    logic [wsr_pkg::BANK_W-1:0] b2_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      granted_reg;

    logic [SUM_W-1:0]          sum_lat;
    logic [SUM_W-1:0]          sum_nxt;
    logic [ROW_W-1:0]          row_lat;
    logic [ROW_W-1:0]          row_nxt;

    row_t                      row0;
    row_t                      row1;
    row_t                      row_w1;
    row_t                      row_w2;
    logic [NUM_BUSES-1:0]      full0;
    logic [NUM_BUSES-1:0]      full1;
    logic [NUM_BUSES-1:0]      free0;
    logic [NUM_BUSES-1:0]      free1;
    logic [NUM_BUSES-1:0]      oh1;
    logic [NUM_BUSES-1:0]      oh2;
    logic                      b1_bad;
    logic                      b2_bad;
    logic                      same_bank;
    logic                      two_free;
    logic                      grant;

    // Logical slot s lives in physical row (base + s) modulo the table length.
    always_comb
    begin
        sum_lat = SUM_W'(base_reg) + SUM_W'(latency);
        sum_nxt = sum_lat + SUM_W'(1);
        row_lat = (sum_lat >= SLOTS_S) ? ROW_W'(sum_lat - SLOTS_S) : ROW_W'(sum_lat);
        row_nxt = (sum_nxt >= SLOTS_S) ? ROW_W'(sum_nxt - SLOTS_S) : ROW_W'(sum_nxt);
    end

    assign ram_re      = cmd.capture;
    assign ram_raddr_a = row_lat;
    assign ram_raddr_b = row_nxt;

    assign row0 = ram_rdata_a;
    assign row1 = ram_rdata_b;

    always_comb
    begin
        for (int b = 0; b < NUM_BUSES; b++)
        begin
            full0[b] = row0[b] >= ports_per_slot;
            full1[b] = row1[b] >= ports_per_slot;
            oh1[b]   = int'(b1_reg) == b;
            oh2[b]   = int'(b2_reg) == b;
        end
        free0     = ~full0;
        free1     = ~full1;
        b1_bad    = int'(b1_reg) >= NUM_BUSES;
        b2_bad    = int'(b2_reg) >= NUM_BUSES;
        same_bank = b1_reg == b2_reg;
        two_free  = |(free0 & (free0 - NUM_BUSES'(1)));
    end

    always_comb
    begin
        grant = 1'b1;
        if (!lat_ok_reg || free0 == '0)
        begin
            grant = 1'b0;
        end
        else if (v1_reg)
        begin
            if (b1_bad || (|(full0 & oh1)))
            begin
                grant = 1'b0;
            end
            else if (v2_reg)
            begin
                if (b2_bad)
                begin
                    grant = 1'b0;
                end
                else if (same_bank)
                begin
                    grant = nxt_ok_reg && !(|(full1 & oh2)) && (free1 != '0);
                end
                else
                begin
                    grant = !(|(full0 & oh2)) && two_free;
                end
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BUSES; b++)
        begin
            row_w1[b] = row0[b] + ((oh1[b] || (v2_reg && !same_bank && oh2[b]))
                                   ? wsr_pkg::CNT_W'(1) : wsr_pkg::CNT_W'(0));
            row_w2[b] = row1[b] + (oh2[b] ? wsr_pkg::CNT_W'(1) : wsr_pkg::CNT_W'(0));
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_lat_reg;
        ram_wdata = '0;
        if (cmd.clear_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.tick_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_reg;
        end
        else if (cmd.eval_en)
        begin
            ram_we    = grant && v1_reg;
            ram_waddr = row_lat_reg;
            ram_wdata = row_w1;
        end
        else if (cmd.write2_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = row_nxt_reg;
            ram_wdata = row_w2;
        end
    end

    always_comb
    begin
        base_next    = base_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.tick_en)
        begin
            base_next = (base_reg == LAST_ROW) ? '0 : base_reg + ROW_W'(1);
        end
        if (cmd.clear_en)
        begin
            clr_cnt_next = clr_cnt_reg + ROW_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.eval_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_lat_reg <= row_lat;
            row_nxt_reg <= row_nxt;
            lat_ok_reg  <= SUM_W'(latency) < SLOTS_S;
            nxt_ok_reg  <= (SUM_W'(latency) + SUM_W'(1)) < SLOTS_S;
            v1_reg      <= first_valid;
            v2_reg      <= second_valid;
            b1_reg      <= first_bank;
            b2_reg      <= second_bank;
        end
        if (cmd.eval_en)
        begin
            granted_reg <= grant;
        end
    end

    assign status.clear_last  = clr_cnt_reg == LAST_ROW;
    assign status.need_write2 = grant && v1_reg && v2_reg && same_bank;
    assign status.out_busy    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;

endmodule

// File: rtl/writeback_slot_reservation_top.sv
// Top level of the writeback slot reservation table with its configuration register.
//
// Channel   Direction  Content
// req       in         cmd, latency, first_valid, first_bank, second_valid, second_bank
// resp      out        granted, one transfer per request, none per tick
// APB       in/out     register 0 at byte address 0: ports_per_slot
//
// A tick is handled in the idle state. A request is captured in the idle state and
// evaluated in the evaluation state, followed by a second write state when a same-bank
// second access is granted, because its rows come through the registered read ports of
// the slot RAM and the RAM has one write port. After reset a clearing pass zeroes
// every row of the RAM; no transfer is accepted on req during that pass.
// A result that waits on resp holds the next request in its evaluation cycle.
module writeback_slot_reservation_top #(
    parameter int NUM_BUSES     = wsr_pkg::WSR_NUM_BUSES,
    parameter int LATENCY_SLOTS = wsr_pkg::WSR_LATENCY_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wsr_req_if.sink                          req,
    wsr_resp_if.source                       resp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wsr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [wsr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [wsr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int ROW_W  = $clog2(LATENCY_SLOTS);
    localparam int DATA_W = NUM_BUSES * wsr_pkg::CNT_W;

    wsr_pkg::ctrl_cmd_t        cmd;
    wsr_pkg::dp_status_t       status;
    logic [wsr_pkg::CNT_W-1:0] ports_reg;
    logic                      ram_we;
    logic [ROW_W-1:0]          ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [ROW_W-1:0]          ram_raddr_a;
    logic [ROW_W-1:0]          ram_raddr_b;
    logic [DATA_W-1:0]         ram_rdata_a;
    logic [DATA_W-1:0]         ram_rdata_b;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_reg <= wsr_pkg::PORTS_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == wsr_pkg::REG_PORTS_PER_SLOT)
        begin
            ports_reg <= pwdata[wsr_pkg::CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == wsr_pkg::REG_PORTS_PER_SLOT)
                    ? wsr_pkg::CFG_DATA_W'(ports_reg) : '0;

    assign req.ready = cmd.in_ready;

    wsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .status   (status),
        .cmd      (cmd)
    );

    wsr_dp #(
        .NUM_BUSES     (NUM_BUSES),
        .LATENCY_SLOTS (LATENCY_SLOTS),
        .ROW_W         (ROW_W),
        .DATA_W        (DATA_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .latency        (req.latency),
        .first_valid    (req.first_valid),
        .first_bank     (req.first_bank),
        .second_valid   (req.second_valid),
        .second_bank    (req.second_bank),
        .ports_per_slot (ports_reg),
        .out_ready      (resp.ready),
        .out_valid      (resp.valid),
        .granted        (resp.granted),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr_a    (ram_raddr_a),
        .ram_raddr_b    (ram_raddr_b),
        .ram_rdata_a    (ram_rdata_a),
        .ram_rdata_b    (ram_rdata_b)
    );

    wsr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LATENCY_SLOTS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

endmodule

// File: test/writeback_slot_reservation_top_test.sv
// Testbench for the writeback slot reservation table with directed and random traffic.
`timescale 1ns / 100ps

module writeback_slot_reservation_top_test;

    localparam int NUM_BUSES        = wsr_pkg::WSR_NUM_BUSES;
    localparam int LATENCY_SLOTS    = wsr_pkg::WSR_LATENCY_SLOTS;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 132;
    localparam int MAX_IDLE         = 17;

    typedef struct packed {
        logic                       cmd;
        logic [wsr_pkg::LAT_W-1:0]  latency;
        logic                       first_valid;
        logic [wsr_pkg::BANK_W-1:0] first_bank;
        logic                       second_valid;
        logic [wsr_pkg::BANK_W-1:0] second_bank;
    } resv_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [wsr_pkg::CFG_ADDR_W-1:0] paddr;
    logic [wsr_pkg::CFG_DATA_W-1:0] pwdata;
    logic [wsr_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    wsr_req_if  req_ch();
    wsr_resp_if resp_ch();

    logic [wsr_pkg::CNT_W-1:0] slot_cnt [NUM_BUSES][LATENCY_SLOTS];
    logic [wsr_pkg::CNT_W-1:0] ports_cfg;
    logic                      pending_grants [$];
    logic                      expected_grant;
    int                        error_count = 0;
    int                        cycle_count = 0;
    int                        send_idle_max = MAX_IDLE;
    int                        recv_idle_max = MAX_IDLE;

    writeback_slot_reservation_top #(
        .NUM_BUSES    (NUM_BUSES),
        .LATENCY_SLOTS(LATENCY_SLOTS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .resp   (resp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic bus_full_at(input int bus, input int slot);
        return slot_cnt[bus][slot] >= ports_cfg;
    endfunction

    function automatic int free_buses_at(input int slot);
        int n;
        n = 0;
        for (int b = 0; b < NUM_BUSES; b++)
        begin
            if (!bus_full_at(b, slot))
                n++;
        end
        return n;
    endfunction

    function automatic void take_slot(input int bus, input int slot);
        slot_cnt[bus][slot] = slot_cnt[bus][slot] + 1'b1;
    endfunction

    function automatic void shift_slots();
        for (int b = 0; b < NUM_BUSES; b++)
        begin
            for (int s = 0; s + 1 < LATENCY_SLOTS; s++)
                slot_cnt[b][s] = slot_cnt[b][s + 1];
            slot_cnt[b][LATENCY_SLOTS - 1] = '0;
        end
    endfunction

    function automatic logic predict_grant(input resv_item_t it);
        int lat;
        int nxt;
        int free_now;
        int b1;
        int b2;
        lat = int'(it.latency);
        b1  = int'(it.first_bank);
        b2  = int'(it.second_bank);
        if (lat >= LATENCY_SLOTS)
            return 1'b0;
        free_now = free_buses_at(lat);
        if (free_now == 0)
            return 1'b0;
        if (!it.first_valid)
            return 1'b1;
        if (b1 >= NUM_BUSES || bus_full_at(b1, lat))
            return 1'b0;
        if (it.second_valid)
        begin
            if (b2 >= NUM_BUSES)
                return 1'b0;
            if (b2 == b1)
            begin
                nxt = lat + 1;
                if (nxt >= LATENCY_SLOTS)
                    return 1'b0;
                if (bus_full_at(b2, nxt) || free_buses_at(nxt) == 0)
                    return 1'b0;
                take_slot(b2, nxt);
            end
            else
            begin
                if (bus_full_at(b2, lat) || free_now <= 1)
                    return 1'b0;
                take_slot(b2, lat);
            end
        end
        take_slot(b1, lat);
        return 1'b1;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %0d at cycle %0d: %s", error_count, cycle_count, msg);
    endfunction

    function automatic resv_item_t request_item(input int lat, input bit fv, input int fb,
                                                input bit sv, input int sb);
        resv_item_t it;
        it.cmd          = wsr_pkg::CMD_REQUEST;
        it.latency      = wsr_pkg::LAT_W'(lat);
        it.first_valid  = fv;
        it.first_bank   = wsr_pkg::BANK_W'(fb);
        it.second_valid = sv;
        it.second_bank  = wsr_pkg::BANK_W'(sb);
        return it;
    endfunction

    function automatic resv_item_t tick_item();
        resv_item_t it;
        it = request_item($urandom, $urandom_range(0, 1), $urandom, $urandom_range(0, 1),
                          $urandom);
        it.cmd = wsr_pkg::CMD_TICK;
        return it;
    endfunction

    function automatic resv_item_t draw_item(input int window);
        resv_item_t it;
        if ($urandom_range(0, 3) == 0)
            return tick_item();
        it = request_item($urandom_range(0, window), $urandom_range(0, 9) != 0,
                          $urandom_range(0, NUM_BUSES - 1), $urandom_range(0, 1),
                          $urandom_range(0, NUM_BUSES - 1));
        case ($urandom_range(0, 9))
            0: it.latency = wsr_pkg::LAT_W'($urandom);
            1: it.latency = wsr_pkg::LAT_W'(LATENCY_SLOTS - 1 - $urandom_range(0, 1));
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            it.second_bank = it.first_bank;
        return it;
    endfunction

    task automatic send_item(input resv_item_t it);
        int   gap;
        logic predicted;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.cmd          = it.cmd;
        req_ch.latency      = it.latency;
        req_ch.first_valid  = it.first_valid;
        req_ch.first_bank   = it.first_bank;
        req_ch.second_valid = it.second_valid;
        req_ch.second_bank  = it.second_bank;
        req_ch.valid        = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (it.cmd == wsr_pkg::CMD_REQUEST)
        begin
            predicted      = predict_grant(it);
            pending_grants = {pending_grants, predicted};
        end
        else
        begin
            shift_slots();
        end
        @(negedge clk);
    endtask

    task automatic settle_block();
        req_ch.valid = 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_ports(input logic [wsr_pkg::CNT_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = wsr_pkg::CFG_ADDR_W'(4 * int'(wsr_pkg::REG_PORTS_PER_SLOT));
        pwdata  = $urandom;
        pwdata[wsr_pkg::CNT_W-1:0] = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        ports_cfg = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_reset_value();
        send_item(request_item(0, 1, 0, 0, 0));
        send_item(request_item(0, 1, 0, 0, 0));
        send_item(request_item(0, 0, 2, 1, 2));
        send_item(request_item(0, 1, 1, 1, 2));
        send_item(request_item(0, 1, 3, 1, 0));
        send_item(request_item(0, 1, 3, 0, 0));
        send_item(request_item(0, 0, 0, 0, 0));
        send_item(request_item(63, 1, 3, 1, 3));
        send_item(request_item(62, 1, 2, 1, 2));
        send_item(request_item(63, 1, 2, 0, 0));
        send_item(request_item(63, 1, 0, 1, 3));
        send_item(request_item(10, 1, 1, 0, 0));
        send_item(request_item(9, 1, 1, 1, 1));
        send_item(request_item(20, 1, 0, 1, 1));
        send_item(request_item(20, 1, 2, 1, 3));
        send_item(request_item(19, 1, 0, 1, 0));
        send_item(tick_item());
        send_item(request_item(62, 1, 2, 0, 0));
    endtask

    task automatic test_ports_zero();
        settle_block();
        write_ports(3'd0);
        send_item(request_item(0, 0, 0, 0, 0));
        send_item(request_item(63, 1, 3, 0, 0));
        send_item(tick_item());
    endtask

    task automatic test_ports_lowered();
        settle_block();
        write_ports(3'd7);
        repeat (3) send_item(request_item(5, 1, 0, 0, 0));
        send_item(request_item(4, 1, 0, 1, 0));
        settle_block();
        write_ports(3'd2);
        send_item(request_item(5, 1, 0, 0, 0));
        send_item(request_item(5, 1, 1, 1, 0));
        send_item(request_item(5, 1, 1, 0, 0));
    endtask

    task automatic test_random_traffic();
        int ports_seq [7];
        int window;
        ports_seq = '{1, 7, 2, 5, 3, 6, 4};
        for (int p = 0; p < 7; p++)
        begin
            settle_block();
            write_ports(wsr_pkg::CNT_W'(ports_seq[p]));
            window = $urandom_range(2, 12);
            send_idle_max = (p % 4 == 0 || p % 4 == 2) ? MAX_IDLE : 0;
            recv_idle_max = (p % 4 == 0 || p % 4 == 3) ? MAX_IDLE : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_item(draw_item(window));
        end
    endtask

    initial
    begin
        int stall;
        resp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, recv_idle_max);
            if (stall > 0)
            begin
                resp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            resp_ch.ready = 1'b1;
            @(posedge clk);
            while (resp_ch.valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
        begin
            if (pending_grants.size() == 0)
                note_error($sformatf("unexpected transfer, granted=%b", resp_ch.granted));
            else
            begin
                expected_grant = pending_grants.pop_front();
                if (resp_ch.granted !== expected_grant)
                    note_error($sformatf("granted expected %b actual %b",
                                         expected_grant, resp_ch.granted));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = wsr_pkg::CMD_TICK;
        req_ch.latency      = '0;
        req_ch.first_valid  = 1'b0;
        req_ch.first_bank   = '0;
        req_ch.second_valid = 1'b0;
        req_ch.second_bank  = '0;
        ports_cfg           = wsr_pkg::PORTS_RESET;
        for (int b = 0; b < NUM_BUSES; b++)
        begin
            for (int s = 0; s < LATENCY_SLOTS; s++)
                slot_cnt[b][s] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_value();
        test_ports_zero();
        test_ports_lowered();
        test_random_traffic();

        settle_block();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: writeback_slot_reservation_top.f
rtl/wsr_pkg.sv
rtl/wsr_req_if.sv
rtl/wsr_resp_if.sv
rtl/wsr_ram.sv
rtl/wsr_ctrl.sv
rtl/wsr_dp.sv
rtl/writeback_slot_reservation_top.sv
test/writeback_slot_reservation_top_test.sv
